// ----- sv/ikhm_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ikhm_pkg
// Shared types and constants of the integer key hash map.
// ============================================================================
package ikhm_pkg;

    localparam int SLOT_W     = 10;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int ENTRIES_W  = 11;
    localparam int LOAD_NUM   = 75;
    localparam int LOAD_DEN   = 100;
    localparam int LOAD_LIMIT = SLOTS * LOAD_NUM / LOAD_DEN;

    localparam logic [KEY_W-1:0] HASH_BASIS = 64'hcbf29ce484222325;
    localparam logic [KEY_W-1:0] HASH_MULT  = 64'h00000100000001b3;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [VAL_W-1:0]     value_out;
        logic [1:0]           status;
        logic [ENTRIES_W-1:0] entries;
    } rsp_t;

endpackage

// ----- sv/ikhm_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ikhm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module ikhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/integer_key_hash_map.sv -----
`timescale 1ns / 1ps
// ============================================================================
// integer_key_hash_map
// Open-addressing map from 64-bit keys to 32-bit values, linear probing.
// ============================================================================
// Usage: a command beat (req: mode, key, value_in) is taken on a clock edge
// with start high and busy low. Exactly one response beat (rsp: hit,
// value_out, status, entries) follows, shown on rsp with done high for a
// single cycle; the receiver cannot stall it. busy stays high from the
// accepting edge until the cycle in which done is raised, so one command
// is in flight at a time. A key of zero is handled as all ones.
// Steps: a hash step, then a key RAM read step and a compare step per
// probed slot, then a finish step that updates and responds. A hit stops
// the probe; a miss scans every slot from the home slot to the last one,
// so the probe loop over the key RAM read port sets the command time.
// Throughput: the next command can be taken in the cycle done is high.
// Reset: the key RAM is swept to zero, one slot per cycle, with busy high
// until every slot is cleared; the entry count resets to zero.
// ============================================================================
module integer_key_hash_map
    import ikhm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_READ   = 6'b001000,
        S_CMP    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] HASH_MULT_LO = HASH_MULT[SLOT_W-1:0];
    localparam logic [CNT_W-1:0]  CNT_LIMIT    = CNT_W'(LOAD_LIMIT);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [SLOT_W-1:0]   home_reg, home_next;
    logic [SLOT_W-1:0]   probe_reg, probe_next;
    logic [SLOT_W-1:0]   empty_reg, empty_next;
    logic                empty_found_reg, empty_found_next;
    logic                hit_reg, hit_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;
    logic [1:0]          mode_reg, mode_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    vin_reg, vin_next;
    logic [VAL_W-1:0]    val_reg, val_next;

    logic [KEY_W-1:0]    hash_x;
    logic                key_we;
    logic [SLOT_W-1:0]   key_waddr;
    logic [KEY_W-1:0]    key_wdata;
    logic [KEY_W-1:0]    key_rdata;
    logic                val_we;
    logic [SLOT_W-1:0]   val_waddr;
    logic [VAL_W-1:0]    val_wdata;
    logic [VAL_W-1:0]    val_rdata;

    ikhm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (probe_reg),
        .rdata (key_rdata)
    );

    ikhm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (probe_reg),
        .rdata (val_rdata)
    );

    assign hash_x = key_reg ^ HASH_BASIS;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        home_next        = home_reg;
        probe_next       = probe_reg;
        empty_next       = empty_reg;
        empty_found_next = empty_found_reg;
        hit_next         = hit_reg;
        cnt_next         = cnt_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        vin_next         = vin_reg;
        val_next         = val_reg;
        key_we           = 1'b0;
        key_waddr        = clr_reg;
        key_wdata        = '0;
        val_we           = 1'b0;
        val_waddr        = probe_reg;
        val_wdata        = vin_reg;

        case (state_reg)
            S_CLEAR:
            begin
                key_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = req.mode;
                    key_next   = (req.key == '0) ? '1 : req.key;
                    vin_next   = req.value_in;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                // low bits of the 64-bit product depend only on low bits
                home_next        = SLOT_W'(hash_x[SLOT_W-1:0] * HASH_MULT_LO);
                probe_next       = home_next;
                empty_found_next = 1'b0;
                hit_next         = 1'b0;
                state_next       = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_rdata == key_reg)
                begin
                    hit_next   = 1'b1;
                    val_next   = val_rdata;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (key_rdata == '0 && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_next       = probe_reg;
                    end
                    if (probe_reg == SLOT_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_FINISH:
            begin
                rsp_next.hit       = hit_reg;
                rsp_next.value_out = '0;
                rsp_next.status    = ST_DONE;
                case (mode_reg)
                    MODE_SET:
                    begin
                        if (hit_reg)
                        begin
                            val_we = 1'b1;
                        end
                        else if (cnt_reg >= CNT_LIMIT || !empty_found_reg)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            key_we    = 1'b1;
                            key_waddr = empty_reg;
                            key_wdata = key_reg;
                            val_we    = 1'b1;
                            val_waddr = empty_reg;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.value_out = val_reg;
                            key_we             = 1'b1;
                            key_waddr          = probe_reg;
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            rsp_next.status = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.value_out = val_reg;
                        end
                        else
                        begin
                            rsp_next.status = ST_ABSENT;
                        end
                    end
                endcase
                rsp_next.entries = ENTRIES_W'(cnt_next);
                done_next        = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            cnt_reg         <= '0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            cnt_reg         <= cnt_next;
            done_reg        <= done_next;
            hit_reg         <= hit_next;
            empty_found_reg <= empty_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg  <= home_next;
        probe_reg <= probe_next;
        empty_reg <= empty_next;
        rsp_reg   <= rsp_next;
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        vin_reg   <= vin_next;
        val_reg   <= val_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FINISH))
        else $error("response beat without a finish step");

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LIMIT)
        else $error("entry count above load limit");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status == ST_FULL |-> !rsp_reg.hit && mode_reg == MODE_SET)
        else $error("full status on a hit or a non-set command");

    a_absent_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status == ST_ABSENT |-> !rsp_reg.hit)
        else $error("absent status on a hit");

    a_probe_above_home: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> probe_reg >= home_reg)
        else $error("probe below home slot");

endmodule

// ----- tb/tb_integer_key_hash_map.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_integer_key_hash_map
// Self-checking bench for the integer key hash map. Commands go in one beat
// at a time through the start/busy handshake. A behavioural copy of the
// table predicts every response beat. Directed tests cover these cases:
// key zero, probing past holes left by remove, no free slot above the home
// slot, the load limit, and the unused mode. A random phase then mixes
// live keys, fresh keys and colliding keys. Sender gaps are random or zero.
// ============================================================================
module tb_integer_key_hash_map;
    import ikhm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_CMDS = 450;
    localparam int TAIL_CYCLES = 50;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    logic [KEY_W-1:0] map_keys [SLOTS];
    logic [VAL_W-1:0] map_vals [SLOTS];
    int               map_count;

    rsp_t due_rsps [$];
    int   mismatches = 0;
    int   stall_cycles = 0;
    bit   no_idle = 1'b0;

    integer_key_hash_map dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned home_of(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] prod;
        prod = (k ^ HASH_BASIS) * HASH_MULT;
        return 32'(prod[SLOT_W-1:0]);
    endfunction

    // only the low key bits decide the home slot, so one of 1024 candidates fits
    function automatic logic [KEY_W-1:0] key_at_home(input int unsigned slot,
                                                     input logic [KEY_W-1:0] seed);
        logic [KEY_W-1:0] k;
        k = seed;
        for (int j = 0; j < SLOTS; j++)
        begin
            k = {seed[KEY_W-1:SLOT_W], j[SLOT_W-1:0]};
            if (home_of(k) == slot)
                return k;
        end
        return k;
    endfunction

    function automatic rsp_t apply_map_cmd(input req_t c);
        logic [KEY_W-1:0] k;
        int unsigned      home;
        int               pos;
        rsp_t             r;
        k    = (c.key == '0) ? '1 : c.key;
        home = home_of(k);
        pos  = SLOTS;
        for (int i = home; i < SLOTS; i++)
        begin
            if (map_keys[i] == k)
            begin
                pos = i;
                break;
            end
        end
        r     = '0;
        r.hit = (pos < SLOTS);
        case (c.mode)
            MODE_SET:
            begin
                if (r.hit)
                    map_vals[pos] = c.value_in;
                else if (map_count >= LOAD_LIMIT)
                    r.status = ST_FULL;
                else
                begin
                    r.status = ST_FULL;
                    for (int i = home; i < SLOTS; i++)
                    begin
                        if (map_keys[i] == '0)
                        begin
                            map_keys[i] = k;
                            map_vals[i] = c.value_in;
                            map_count++;
                            r.status = ST_DONE;
                            break;
                        end
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (r.hit)
                begin
                    r.value_out   = map_vals[pos];
                    map_keys[pos] = '0;
                    map_vals[pos] = '0;
                    if (map_count > 0)
                        map_count--;
                end
                else
                    r.status = ST_ABSENT;
            end
            default:
            begin
                if (r.hit)
                    r.value_out = map_vals[pos];
                else
                    r.status = ST_ABSENT;
            end
        endcase
        r.entries = map_count[ENTRIES_W-1:0];
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic issue_cmd(input logic [1:0] cmd_mode, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        int   gap;
        req_t c;
        gap        = no_idle ? 0 : $urandom_range(0, 19);
        c.mode     = cmd_mode;
        c.key      = key;
        c.value_in = value;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        req   = c;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
        due_rsps.push_back(apply_map_cmd(c));
    endtask

    task automatic wait_for_idle();
        while (due_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (due_rsps.size() == 0)
            begin
                $display("%0t: response beat with none due, actual %p", $time, rsp);
                mismatches++;
            end
            else
            begin
                want = due_rsps.pop_front();
                check_field("hit", 64'(want.hit), 64'(rsp.hit));
                check_field("value_out", 64'(want.value_out), 64'(rsp.value_out));
                check_field("status", 64'(want.status), 64'(rsp.status));
                check_field("entries", 64'(want.entries), 64'(rsp.entries));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_basic_ops();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        issue_cmd(MODE_LOOKUP, k, $urandom);
        issue_cmd(MODE_SET, k, 32'h0000_0000);
        issue_cmd(MODE_LOOKUP, k, $urandom);
        issue_cmd(MODE_SET, k, 32'hffff_ffff);
        issue_cmd(MODE_LOOKUP, k, 32'h0000_0000);
        issue_cmd(MODE_REMOVE, k, $urandom);
        issue_cmd(MODE_REMOVE, k, $urandom);
        issue_cmd(MODE_LOOKUP, k, $urandom);
    endtask

    task automatic test_key_extremes();
        issue_cmd(MODE_SET, '0, 32'hffff_ffff);
        issue_cmd(MODE_LOOKUP, '1, 32'h0);
        issue_cmd(MODE_SET, '1, 32'h5a5a_a5a5);
        issue_cmd(MODE_UNUSED, '0, 32'h0);
        issue_cmd(MODE_SET, 64'h1, 32'h1);
        issue_cmd(MODE_SET, 64'h8000_0000_0000_0000, 32'h8000_0000);
        issue_cmd(MODE_REMOVE, '0, 32'h0);
        issue_cmd(MODE_REMOVE, 64'h1, 32'h0);
        issue_cmd(MODE_REMOVE, 64'h8000_0000_0000_0000, 32'h0);
    endtask

    task automatic test_no_free_slot();
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        ka = key_at_home(SLOTS - 1, 64'h1234_5678_9abc_d000);
        kb = key_at_home(SLOTS - 1, 64'h0fed_cba9_8765_4000);
        issue_cmd(MODE_SET, ka, $urandom);
        issue_cmd(MODE_SET, kb, $urandom);
        issue_cmd(MODE_LOOKUP, kb, $urandom);
        issue_cmd(MODE_REMOVE, ka, $urandom);
        issue_cmd(MODE_SET, kb, $urandom);
        issue_cmd(MODE_REMOVE, kb, $urandom);
    endtask

    task automatic test_probe_holes();
        logic [KEY_W-1:0] chain [4];
        for (int i = 0; i < 4; i++)
            chain[i] = key_at_home(1000, {32'h7700_0000 + i, 32'h0});
        for (int i = 0; i < 3; i++)
            issue_cmd(MODE_SET, chain[i], $urandom);
        issue_cmd(MODE_REMOVE, chain[1], $urandom);
        issue_cmd(MODE_LOOKUP, chain[2], $urandom);
        issue_cmd(MODE_SET, chain[3], $urandom);
        issue_cmd(MODE_SET, chain[2], $urandom);
        issue_cmd(MODE_REMOVE, chain[0], $urandom);
        issue_cmd(MODE_REMOVE, chain[2], $urandom);
        issue_cmd(MODE_REMOVE, chain[3], $urandom);
    endtask

    // one key per home slot from the top down keeps every insert at its home slot
    task automatic test_load_limit();
        logic [KEY_W-1:0] fill_keys [$];
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] spare;
        for (int h = SLOTS - 1; h >= SLOTS - LOAD_LIMIT; h--)
        begin
            k = key_at_home(h, {22'h15a5a5, 32'(h), 10'h0});
            fill_keys.push_back(k);
            issue_cmd(MODE_SET, k, $urandom);
        end
        spare = key_at_home(5, 64'h0bad_cafe_0000_0000);
        issue_cmd(MODE_SET, spare, $urandom);
        issue_cmd(MODE_SET, fill_keys[0], $urandom);
        issue_cmd(MODE_LOOKUP, fill_keys[0], $urandom);
        wait_for_idle();
        issue_cmd(MODE_REMOVE, fill_keys[LOAD_LIMIT - 1], $urandom);
        issue_cmd(MODE_SET, spare, $urandom);
        issue_cmd(MODE_LOOKUP, spare, $urandom);
        issue_cmd(MODE_REMOVE, spare, $urandom);
        for (int i = 0; i < LOAD_LIMIT - 1; i++)
            issue_cmd(MODE_REMOVE, fill_keys[i], $urandom);
    endtask

    task automatic test_random_mix();
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] seed;
        logic [1:0]       cmd_mode;
        int               sel;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399)
                wait_for_idle();
            sel = $urandom_range(0, 99);
            if (sel < 35)
                cmd_mode = MODE_LOOKUP;
            else if (sel < 75)
                cmd_mode = MODE_SET;
            else if (sel < 95)
                cmd_mode = MODE_REMOVE;
            else
                cmd_mode = MODE_UNUSED;
            if (key_pool.size() != 0 && $urandom_range(0, 99) < 60)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
            begin
                seed = {$urandom, $urandom};
                if ($urandom_range(0, 49) == 0)
                    key = '0;
                else if ($urandom_range(0, 1) == 1)
                    key = seed;
                else
                    key = key_at_home($urandom_range(SLOTS - 64, SLOTS - 1), seed);
                key_pool.push_back(key);
            end
            issue_cmd(cmd_mode, key, $urandom);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        foreach (map_keys[i])
        begin
            map_keys[i] = '0;
            map_vals[i] = '0;
        end
        map_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_basic_ops();
        test_key_extremes();
        test_no_free_slot();
        test_probe_holes();
        test_load_limit();
        test_random_mix();
        start = 1'b0;
        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
